/* src/asfs_pkg.sv */
// ----------------------------------------------------------------------------
// asfs_pkg
// Shared types, constants and the sampling rate table of the ADTS splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package asfs_pkg;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_HEADER = 2'd1,
    PH_FRAME  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SYNC  = 2'd1,
    ST_BAD_RATE  = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_DIV  = 2'd2,
    BK_HOLD = 2'd3
  } back_state_e;

  // Sync word
  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] SYNC2_MASK = 8'hF6;
  localparam logic [7:0] SYNC2_VAL  = 8'hF0;

  // Byte positions within the header
  localparam logic [12:0] POS_PROFILE = 13'd2;
  localparam logic [12:0] POS_CHAN    = 13'd3;
  localparam logic [12:0] POS_LEN_MID = 13'd4;
  localparam logic [12:0] POS_LEN_LO  = 13'd5;
  localparam logic [12:0] POS_PAYLOAD = 13'd6;

  localparam logic [3:0]  RATE_IDX_LIMIT = 4'd12;
  localparam logic [12:0] MIN_FRAME_LEN  = 13'd7;

  // 1024 samples * 1e6 us = 15625 << 16
  localparam int          US_SHIFT = 16;
  localparam logic [13:0] US_ODD   = 14'd15625;
  localparam int          RATE_W   = 17;
  localparam logic [62:0] TIME_MAX = '1;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        frame_end;
    logic        mpeg_version;
    logic [1:0]  profile;
    logic [2:0]  channel_config;
    logic [3:0]  rate_index;
    logic [12:0] frame_bytes;
    status_e     status;
    logic        run_last;
  } item_t;

  function automatic logic [RATE_W-1:0] rate_hz(input logic [3:0] idx);
    logic [RATE_W-1:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      default: r = 17'd8000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/asfs_front.sv */
// ----------------------------------------------------------------------------
// asfs_front
// Sync hunt and header decode; writes zero, one or two result entries per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module asfs_front
  import asfs_pkg::*;
#(
  parameter int COUNT_BITS = 32,
  parameter int ENTRY_W    = $bits(item_t) + COUNT_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         byte_i,
  output logic      [1:0]         wr_num_o,
  output logic      [ENTRY_W-1:0] wr0_o,
  output logic      [ENTRY_W-1:0] wr1_o
);

  phase_e                phase_q, phase_d;
  logic                  held_q, held_d;
  logic [12:0]           pos_q, pos_d;
  logic                  ver_q, ver_d;
  logic [1:0]            obj_q, obj_d;
  logic [3:0]            rate_q, rate_d;
  logic [2:0]            chan_q, chan_d;
  logic [12:0]           len_q, len_d;
  logic [COUNT_BITS-1:0] frames_q, frames_d;

  logic        strict;
  logic [13:0] pos_inc;
  logic [12:0] len_lo;
  logic        emit_sync, emit_fail, emit_frame, frame_done;
  status_e     fail_st;
  item_t       base, it0, it1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      held_q   <= 1'b0;
      pos_q    <= '0;
      ver_q    <= 1'b0;
      obj_q    <= '0;
      rate_q   <= '0;
      chan_q   <= '0;
      len_q    <= '0;
      frames_q <= '0;
    end else begin
      phase_q  <= phase_d;
      held_q   <= held_d;
      pos_q    <= pos_d;
      ver_q    <= ver_d;
      obj_q    <= obj_d;
      rate_q   <= rate_d;
      chan_q   <= chan_d;
      len_q    <= len_d;
      frames_q <= frames_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    pos_d      = pos_q;
    ver_d      = ver_q;
    obj_d      = obj_q;
    rate_d     = rate_q;
    chan_d     = chan_q;
    len_d      = len_q;
    frames_d   = frames_q;
    emit_sync  = 1'b0;
    emit_fail  = 1'b0;
    emit_frame = 1'b0;
    frame_done = 1'b0;
    fail_st    = ST_OK;
    strict     = (phase_q == PH_HEADER);
    pos_inc    = {1'b0, pos_q} + 14'd1;
    len_lo     = {len_q[12:3], byte_i[7:5]};

    if (accept_i) begin
      case (phase_q)
        PH_FRAME: begin
          if (pos_q == POS_PROFILE) begin
            obj_d  = byte_i[7:6];
            rate_d = byte_i[5:2];
            chan_d = {byte_i[0], 2'b00};
            if (byte_i[5:2] >= RATE_IDX_LIMIT) begin
              emit_fail = 1'b1;
              fail_st   = ST_BAD_RATE;
            end
          end else if (pos_q == POS_CHAN) begin
            chan_d = {chan_q[2], byte_i[7:6]};
            len_d  = {byte_i[1:0], 11'd0};
          end else if (pos_q == POS_LEN_MID) begin
            len_d = {len_q[12:11], byte_i, 3'd0};
          end else if (pos_q == POS_LEN_LO) begin
            len_d = len_lo;
            if (len_lo < MIN_FRAME_LEN) begin
              emit_fail = 1'b1;
              fail_st   = ST_TOO_SHORT;
            end
          end
          if (!emit_fail) begin
            emit_frame = 1'b1;
            if (pos_q >= POS_PAYLOAD && pos_inc >= {1'b0, len_d}) begin
              frame_done = 1'b1;
              frames_d   = frames_q + 1'b1;
              phase_d    = PH_HEADER;
              held_d     = 1'b0;
              pos_d      = '0;
            end else begin
              pos_d = pos_inc[12:0];
            end
          end
        end
        default: begin
          if (held_q) begin
            if ((byte_i & SYNC2_MASK) == SYNC2_VAL) begin
              held_d    = 1'b0;
              phase_d   = PH_FRAME;
              pos_d     = POS_PROFILE;
              ver_d     = byte_i[3];
              obj_d     = '0;
              rate_d    = '0;
              chan_d    = '0;
              len_d     = '0;
              emit_sync = 1'b1;
            end else if (strict) begin
              emit_fail = 1'b1;
              fail_st   = ST_BAD_SYNC;
            end else begin
              held_d = (byte_i == SYNC_BYTE);
            end
          end else if (byte_i == SYNC_BYTE) begin
            held_d = 1'b1;
          end else if (strict) begin
            emit_fail = 1'b1;
            fail_st   = ST_BAD_SYNC;
          end
        end
      endcase
      // drop back to hunting; a failing 0xFF becomes the new candidate
      if (emit_fail) begin
        phase_d = PH_SEARCH;
        held_d  = (byte_i == SYNC_BYTE);
        pos_d   = '0;
      end
    end

    base                = '0;
    base.mpeg_version   = ver_d;
    base.profile        = obj_d;
    base.channel_config = chan_d;
    base.rate_index     = rate_d;
    base.frame_bytes    = len_d;
    base.status         = ST_OK;

    it0           = base;
    it0.out_byte  = emit_sync ? SYNC_BYTE : byte_i;
    it0.out_valid = emit_sync | emit_frame;
    it0.frame_end = frame_done;
    it0.status    = fail_st;
    it0.run_last  = !emit_sync;

    it1           = base;
    it1.out_byte  = byte_i;
    it1.out_valid = 1'b1;
    it1.run_last  = 1'b1;

    if (emit_sync) begin
      wr_num_o = 2'd2;
    end else if (emit_fail || emit_frame) begin
      wr_num_o = 2'd1;
    end else begin
      wr_num_o = 2'd0;
    end
    wr0_o = {it0, frames_d};
    wr1_o = {it1, frames_d};
  end

endmodule

`default_nettype wire

/* src/asfs_fifo.sv */
// ----------------------------------------------------------------------------
// asfs_fifo
// Short result queue between front and back; takes up to two entries a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module asfs_fifo
  import asfs_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       wr_num_i,
  input  wire logic [WIDTH-1:0] wr0_i,
  input  wire logic [WIDTH-1:0] wr1_i,
  input  wire logic             rd_en_i,
  output logic      [WIDTH-1:0] rd_data_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_nx;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign wptr_nx   = wptr_q + 1'b1;
  assign rd_data_o = mem_q[rptr_q];
  assign empty_o   = (cnt_q == '0);
  // hold off the front unless two slots are free
  assign full_o    = (cnt_q > CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wptr_d = wptr_q + PTR_W'(wr_num_i);
    rptr_d = rd_en_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + CNT_W'(wr_num_i) - CNT_W'(rd_en_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_num_i != 2'd0) begin
      mem_q[wptr_q] <= wr0_i;
    end
    if (wr_num_i == 2'd2) begin
      mem_q[wptr_nx] <= wr1_i;
    end
  end

endmodule

`default_nettype wire

/* src/asfs_back.sv */
// ----------------------------------------------------------------------------
// asfs_back
// Result stage: send time by multiply and bit-serial divide, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module asfs_back
  import asfs_pkg::*;
#(
  parameter int COUNT_BITS = 32,
  parameter int ENTRY_W    = $bits(item_t) + COUNT_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire logic [ENTRY_W-1:0] q_data_i,
  output logic                    q_rd_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output item_t                   item_o,
  output logic      [31:0]        frame_count_o,
  output logic      [62:0]        time_us_o
);

  localparam int QW    = COUNT_BITS + 14 + US_SHIFT;
  localparam int QXW   = (QW > 63) ? QW : 64;
  localparam int CNT_W = $clog2(QW);

  back_state_e           state_q, state_d;
  logic                  out_v_q, out_v_d;
  item_t                 out_item_q, out_item_d;
  logic [COUNT_BITS-1:0] out_frames_q, out_frames_d;
  logic [62:0]           out_time_q, out_time_d;
  item_t                 job_item_q, job_item_d;
  logic [COUNT_BITS-1:0] job_frames_q, job_frames_d;
  logic [RATE_W-1:0]     rate_q, rate_d;
  logic [QW-1:0]         dvd_q, dvd_d;
  logic [RATE_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  item_t                 head_item;
  logic [COUNT_BITS-1:0] head_frames;
  logic                  out_free;
  logic [COUNT_BITS+13:0] prod;
  logic [RATE_W:0]       rem2;
  logic                  ge;
  logic [QXW-1:0]        q_ext;
  logic                  sat;

  assign {head_item, head_frames} = q_data_i;
  assign out_free      = !out_v_q || pop_i;
  assign empty_o       = !out_v_q;
  assign item_o        = out_item_q;
  assign frame_count_o = 32'(out_frames_q);
  assign time_us_o     = out_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q   <= out_item_d;
    out_frames_q <= out_frames_d;
    out_time_q   <= out_time_d;
    job_item_q   <= job_item_d;
    job_frames_q <= job_frames_d;
    rate_q       <= rate_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    cnt_q        <= cnt_d;
  end

  always_comb begin
    state_d      = state_q;
    out_v_d      = out_v_q && !pop_i;
    out_item_d   = out_item_q;
    out_frames_d = out_frames_q;
    out_time_d   = out_time_q;
    job_item_d   = job_item_q;
    job_frames_d = job_frames_q;
    rate_d       = rate_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    q_rd_o       = 1'b0;
    prod         = job_frames_q * US_ODD;
    rem2         = {rem_q, dvd_q[QW-1]};
    ge           = (rem2 >= {1'b0, rate_q});
    q_ext        = QXW'(dvd_q);
    sat          = |q_ext[QXW-1:63];

    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (head_item.frame_end) begin
            q_rd_o       = 1'b1;
            job_item_d   = head_item;
            job_frames_d = head_frames;
            state_d      = BK_MUL;
          end else if (out_free) begin
            q_rd_o       = 1'b1;
            out_v_d      = 1'b1;
            out_item_d   = head_item;
            out_frames_d = head_frames;
            out_time_d   = '0;
          end
        end
      end
      BK_MUL: begin
        dvd_d   = {prod, {US_SHIFT{1'b0}}};
        rate_d  = rate_hz(job_item_q.rate_index);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = BK_DIV;
      end
      BK_DIV: begin
        // one quotient bit per cycle, shifted in behind the dividend
        rem_d = ge ? RATE_W'(rem2 - {1'b0, rate_q}) : rem2[RATE_W-1:0];
        dvd_d = {dvd_q[QW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QW - 1)) begin
          state_d = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          out_v_d      = 1'b1;
          out_item_d   = job_item_q;
          out_frames_d = job_frames_q;
          out_time_d   = sat ? TIME_MAX : q_ext[62:0];
          state_d      = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* src/adts_frame_sync_splitter.sv */
// ----------------------------------------------------------------------------
// adts_frame_sync_splitter
// ADTS byte stream splitter: sync hunt, header decode, frame send time.
// ----------------------------------------------------------------------------
//  Channel   Ports                        Request moves when
//  byte in   push, full, data_byte_i      push && !full
//  result    empty, pop, *_o fields       pop && !empty
//
//  The front takes one byte per cycle while the result queue has two free
//  slots. A result without a send time goes from the queue head into the
//  output register once it is free. A frame's last byte passes the back's
//  multiply step, then a divider that yields one quotient bit per cycle.
//  Reset is asynchronous, active low; all parser state and queues clear.
//  A stalled result side backs up the 4-entry queue; full rises at three entries.
// ----------------------------------------------------------------------------
`default_nettype none

module adts_frame_sync_splitter
  import asfs_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             out_valid_o,
  output logic             frame_end_o,
  output logic [31:0]      frame_count_o,
  output logic [62:0]      time_us_o,
  output logic             mpeg_version_o,
  output logic [1:0]       profile_o,
  output logic [2:0]       channel_config_o,
  output logic [3:0]       rate_index_o,
  output logic [12:0]      frame_bytes_o,
  output logic [1:0]       status_o,
  output logic             run_last_o
);

  localparam int ENTRY_W = $bits(item_t) + COUNT_BITS;

  logic               accept;
  logic [1:0]         wr_num;
  logic [ENTRY_W-1:0] wr0, wr1, q_data;
  logic               q_rd, q_empty;
  item_t              item;

  assign accept = push && !full;

  asfs_front #(
    .COUNT_BITS(COUNT_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (data_byte_i),
    .wr_num_o(wr_num),
    .wr0_o   (wr0),
    .wr1_o   (wr1)
  );

  asfs_fifo #(
    .WIDTH(ENTRY_W)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_num_i (wr_num),
    .wr0_i    (wr0),
    .wr1_i    (wr1),
    .rd_en_i  (q_rd),
    .rd_data_o(q_data),
    .empty_o  (q_empty),
    .full_o   (full)
  );

  asfs_back #(
    .COUNT_BITS(COUNT_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_data),
    .q_rd_o       (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .item_o       (item),
    .frame_count_o(frame_count_o),
    .time_us_o    (time_us_o)
  );

  assign out_byte_o       = item.out_byte;
  assign out_valid_o      = item.out_valid;
  assign frame_end_o      = item.frame_end;
  assign mpeg_version_o   = item.mpeg_version;
  assign profile_o        = item.profile;
  assign channel_config_o = item.channel_config;
  assign rate_index_o     = item.rate_index;
  assign frame_bytes_o    = item.frame_bytes;
  assign status_o         = item.status;
  assign run_last_o       = item.run_last;

endmodule

`default_nettype wire

/* src/asfs_chk.sv */
// ----------------------------------------------------------------------------
// asfs_chk
// Port-level checks of the ADTS splitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module asfs_chk
  import asfs_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [7:0]  out_byte_o,
  input wire logic        out_valid_o,
  input wire logic        frame_end_o,
  input wire logic [62:0] time_us_o,
  input wire logic [1:0]  status_o,
  input wire logic        run_last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(time_us_o)))
    else $error("waiting result changed or vanished");

  a_end_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |->
      (out_valid_o && run_last_o && status_o == ST_OK))
    else $error("frame end on a result that is not a good forwarded byte");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> (!out_valid_o && !frame_end_o && run_last_o))
    else $error("error result carries a forwarded byte");

  a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && time_us_o != '0) |-> frame_end_o)
    else $error("send time outside a frame end");

endmodule

bind adts_frame_sync_splitter asfs_chk u_asfs_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_byte_o (out_byte_o),
  .out_valid_o(out_valid_o),
  .frame_end_o(frame_end_o),
  .time_us_o  (time_us_o),
  .status_o   (status_o),
  .run_last_o (run_last_o)
);

`default_nettype wire
